@@ sv/ttsw_pkg.sv @@
// Shared types and constants for the text terminal screen writer.
package ttsw_pkg;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_COLS = 1'b1;

   localparam logic [6:0] ROWS_RESET = 7'd24;
   localparam logic [7:0] COLS_RESET = 8'd80;

   localparam logic [7:0] CH_BLANK   = 8'h20;
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_COPY,
      S_DRAIN,
      S_FILL,
      S_FINISH
   } ttsw_state_type;

   typedef enum logic [2:0] {
      DC_NONE,
      DC_INIT,
      DC_ACCEPT,
      DC_READ_DONE,
      DC_COPY,
      DC_DRAIN,
      DC_FILL,
      DC_FINISH
   } ttsw_cmd_type;

   typedef enum logic [1:0] {
      K_SIMPLE,
      K_READ,
      K_CLEAR,
      K_SCROLL
   } ttsw_kind_type;

   typedef struct packed {
      logic          init_last;
      logic          copy_last;
      logic          fill_last;
      logic          one_row;
      logic          fifo_room;
      ttsw_kind_type kind;
   } ttsw_status_type;

   // first member lands in the top bits, so cursor row sits lowest
   typedef struct packed {
      logic       did_scroll;
      logic       escape_busy;
      logic [7:0] cell_data;
      logic [7:0] cur_col;
      logic [5:0] cur_row;
   } ttsw_rsp_type;

endpackage

@@ sv/ttsw_ctrl.sv @@
// Sequencer for the screen writer: picks the datapath command each cycle.
module ttsw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  ttsw_pkg::ttsw_status_type status,
   output ttsw_pkg::ttsw_cmd_type    cmd
);
   import ttsw_pkg::*;

   ttsw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = DC_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd = DC_INIT;
            if (status.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = status.fifo_room;
            if (req_tvalid && status.fifo_room) begin
               cmd = DC_ACCEPT;
               case (status.kind)
                  K_READ:   state_in = S_READ;
                  K_CLEAR:  state_in = S_FILL;
                  K_SCROLL: state_in = status.one_row ? S_FILL : S_COPY;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            cmd      = DC_READ_DONE;
            state_in = S_IDLE;
         end
         S_COPY: begin
            cmd = DC_COPY;
            if (status.copy_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd      = DC_DRAIN;
            state_in = S_FILL;
         end
         S_FILL: begin
            cmd = DC_FILL;
            if (status.fill_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd      = DC_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

@@ sv/ttsw_datapath.sv @@
// Cell memory, cursor, escape tracking, sweep counters and result queue.
module ttsw_datapath #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 128,
   parameter int ESC_MAX_LEN = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ttsw_pkg::ttsw_cmd_type                cmd,
   output ttsw_pkg::ttsw_status_type             status,
   input  logic [ttsw_pkg::OP_W-1:0]             req_tuser,
   input  logic [ttsw_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 csr_we,
   input  logic [ttsw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ttsw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ttsw_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import ttsw_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ACW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RUW   = $clog2(MAX_ROWS + 1);
   localparam int CUW   = CW;
   localparam int RCW   = (RUW > 7) ? RUW : 7;
   localparam int CCW   = (CUW > 8) ? CUW : 8;
   localparam int RMW   = (RUW > 6) ? RUW : 6;
   localparam int CMW   = (CUW > 7) ? CUW : 7;
   localparam int AW    = RW + ACW;
   localparam int DEPTH = 1 << AW;
   localparam int EW    = $clog2(ESC_MAX_LEN + 1);

   logic [7:0] mem [DEPTH];

   logic [6:0]     rows_cfg_ff, rows_cfg_in;
   logic [7:0]     cols_cfg_ff, cols_cfg_in;
   logic [RW-1:0]  row_ff, row_in, row_op;
   logic [CW-1:0]  col_ff, col_in, col_op;
   logic           esc_active_ff, esc_active_in;
   logic [EW-1:0]  esc_len_ff, esc_len_in;
   logic [7:0]     char_ff, char_in;
   logic           nl_ff, nl_in;
   logic           clear_mode_ff, clear_mode_in;
   logic           oob_ff, oob_in;
   logic [RW-1:0]  sw_row_ff, sw_row_in;
   logic [ACW-1:0] sw_col_ff, sw_col_in;
   logic [AW-1:0]  init_cnt_ff, init_cnt_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_addr_ff, pend_addr_in;
   logic [7:0]     rdata_ff;
   ttsw_rsp_type   head_ff, tail_ff;
   logic [1:0]     count_ff;

   logic [1:0]     in_op;
   logic [7:0]     in_char;
   logic [5:0]     in_row;
   logic [6:0]     in_col;

   logic [RCW-1:0] rows_ext, rows_ext_new;
   logic [CCW-1:0] cols_ext, cols_ext_new;
   logic [RUW-1:0] rows_used, rows_used_new;
   logic [CUW-1:0] cols_used, cols_used_new;
   logic [RW-1:0]  last_row;
   logic [ACW-1:0] last_col;
   logic           at_bottom, wrap, is_letter;
   ttsw_kind_type  kind;

   logic           we, re, push, pop;
   logic [AW-1:0]  waddr, raddr;
   logic [7:0]     wdata;
   ttsw_rsp_type   push_data;

   assign in_op   = req_tuser;
   assign in_char = req_tdata[7:0];
   assign in_row  = req_tdata[13:8];
   assign in_col  = req_tdata[20:14];

   // configuration registers and the clamped sizes in use
   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SCREEN_ROWS: rows_cfg_in = csr_wdata[6:0];
            REG_SCREEN_COLS: cols_cfg_in = csr_wdata;
            default: begin
               rows_cfg_in = rows_cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      rows_ext     = RCW'(rows_cfg_ff);
      rows_ext_new = RCW'(rows_cfg_in);
      cols_ext     = CCW'(cols_cfg_ff);
      cols_ext_new = CCW'(cols_cfg_in);
      if (rows_ext == '0) rows_used = RUW'(1);
      else if (rows_ext > RCW'(MAX_ROWS)) rows_used = RUW'(MAX_ROWS);
      else rows_used = RUW'(rows_ext);
      if (rows_ext_new == '0) rows_used_new = RUW'(1);
      else if (rows_ext_new > RCW'(MAX_ROWS)) rows_used_new = RUW'(MAX_ROWS);
      else rows_used_new = RUW'(rows_ext_new);
      if (cols_ext == '0) cols_used = CUW'(1);
      else if (cols_ext > CCW'(MAX_COLS)) cols_used = CUW'(MAX_COLS);
      else cols_used = CUW'(cols_ext);
      if (cols_ext_new == '0) cols_used_new = CUW'(1);
      else if (cols_ext_new > CCW'(MAX_COLS)) cols_used_new = CUW'(MAX_COLS);
      else cols_used_new = CUW'(cols_ext_new);
   end

   assign last_row  = RW'(rows_used - RUW'(1));
   assign last_col  = ACW'(cols_used - CUW'(1));
   assign at_bottom = (row_ff >= last_row);
   assign wrap      = (col_ff >= cols_used);
   assign is_letter = ((in_char >= CH_UPPER_A) && (in_char <= CH_UPPER_Z)) ||
                      ((in_char >= CH_LOWER_A) && (in_char <= CH_LOWER_Z));

   // classify the offered beat so the sequencer knows how long it runs
   always_comb begin
      kind = K_SIMPLE;
      case (in_op)
         OP_WRITE: begin
            if (esc_active_ff || in_char == CH_NUL || in_char == CH_ESC ||
                in_char == CH_CR || in_char == CH_BS || in_char == CH_DEL) begin
               kind = K_SIMPLE;
            end else if (in_char == CH_LF) begin
               kind = at_bottom ? K_SCROLL : K_SIMPLE;
            end else begin
               kind = (wrap && at_bottom) ? K_SCROLL : K_SIMPLE;
            end
         end
         OP_MOVE:  kind = K_SIMPLE;
         OP_CLEAR: kind = K_CLEAR;
         OP_READ:  kind = K_READ;
         default:  kind = K_READ;
      endcase
   end

   assign status.init_last = &init_cnt_ff;
   assign status.copy_last = (sw_row_ff == last_row - RW'(1)) && (sw_col_ff == last_col);
   assign status.fill_last = (sw_row_ff == last_row) && (sw_col_ff == last_col);
   assign status.one_row   = (last_row == '0);
   assign status.fifo_room = (count_ff != 2'd2);
   assign status.kind      = kind;

   always_comb begin
      logic [EW-1:0] len1;
      logic [RW-1:0] wr_row;
      logic [CW-1:0] wr_col;
      logic [CW-1:0] bs_col;
      logic          scrolled;
      logic [7:0]    cell_byte;

      len1          = esc_len_ff + EW'(1);
      wr_row        = wrap ? row_ff + RW'(1) : row_ff;
      wr_col        = wrap ? '0 : col_ff;
      bs_col        = col_ff - CW'(1);
      scrolled      = 1'b0;
      cell_byte     = '0;
      row_op        = row_ff;
      col_op        = col_ff;
      esc_active_in = esc_active_ff;
      esc_len_in    = esc_len_ff;
      char_in       = char_ff;
      nl_in         = nl_ff;
      clear_mode_in = clear_mode_ff;
      oob_in        = oob_ff;
      sw_row_in     = sw_row_ff;
      sw_col_in     = sw_col_ff;
      init_cnt_in   = init_cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = CH_BLANK;
      re            = 1'b0;
      raddr         = '0;
      push          = 1'b0;

      // copy write lands in the cycle after its read
      if (pend_ff) begin
         we    = 1'b1;
         waddr = pend_addr_ff;
         wdata = rdata_ff;
      end

      case (cmd)
         DC_INIT: begin
            we          = 1'b1;
            waddr       = init_cnt_ff;
            wdata       = CH_BLANK;
            init_cnt_in = init_cnt_ff + AW'(1);
         end
         DC_ACCEPT: begin
            char_in       = in_char;
            nl_in         = (in_char == CH_LF);
            clear_mode_in = (in_op == OP_CLEAR);
            sw_row_in     = '0;
            sw_col_in     = '0;
            case (kind)
               K_SIMPLE: begin
                  push = 1'b1;
                  if (in_op == OP_MOVE) begin
                     if (RMW'(in_row) < RMW'(rows_used)) row_op = RW'(in_row);
                     if (CMW'(in_col) < CMW'(cols_used)) col_op = CW'(in_col);
                  end else if (esc_active_ff) begin
                     if (in_char == CH_NUL || is_letter || len1 >= EW'(ESC_MAX_LEN)) begin
                        esc_active_in = 1'b0;
                        esc_len_in    = '0;
                     end else begin
                        esc_len_in = len1;
                     end
                  end else if (in_char == CH_NUL) begin
                     esc_active_in = 1'b0;
                  end else if (in_char == CH_ESC) begin
                     esc_active_in = 1'b1;
                     esc_len_in    = '0;
                  end else if (in_char == CH_LF) begin
                     row_op = row_ff + RW'(1);
                     col_op = '0;
                  end else if (in_char == CH_CR) begin
                     col_op = '0;
                  end else if (in_char == CH_BS || in_char == CH_DEL) begin
                     if (col_ff != '0) begin
                        col_op = bs_col;
                        we     = 1'b1;
                        waddr  = {row_ff, bs_col[ACW-1:0]};
                        wdata  = CH_BLANK;
                     end
                  end else begin
                     row_op = wr_row;
                     col_op = wr_col + CW'(1);
                     we     = 1'b1;
                     waddr  = {wr_row, wr_col[ACW-1:0]};
                     wdata  = in_char;
                  end
               end
               K_READ: begin
                  re     = 1'b1;
                  raddr  = {RW'(in_row), ACW'(in_col)};
                  oob_in = !((RMW'(in_row) < RMW'(MAX_ROWS)) &&
                             (CMW'(in_col) < CMW'(MAX_COLS)));
               end
               default: begin
                  oob_in = oob_ff;
               end
            endcase
         end
         DC_READ_DONE: begin
            push      = 1'b1;
            cell_byte = oob_ff ? CH_BLANK : rdata_ff;
         end
         DC_COPY: begin
            re           = 1'b1;
            raddr        = {sw_row_ff + RW'(1), sw_col_ff};
            pend_in      = 1'b1;
            pend_addr_in = {sw_row_ff, sw_col_ff};
            if (sw_col_ff == last_col) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + RW'(1);
            end else begin
               sw_col_in = sw_col_ff + ACW'(1);
            end
         end
         DC_DRAIN: begin
            sw_row_in = last_row;
            sw_col_in = '0;
         end
         DC_FILL: begin
            we    = 1'b1;
            waddr = {sw_row_ff, sw_col_ff};
            wdata = CH_BLANK;
            if (sw_col_ff == last_col) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + RW'(1);
            end else begin
               sw_col_in = sw_col_ff + ACW'(1);
            end
         end
         DC_FINISH: begin
            push = 1'b1;
            if (clear_mode_ff) begin
               row_op = '0;
               col_op = '0;
            end else begin
               scrolled = 1'b1;
               row_op   = last_row;
               if (nl_ff) begin
                  col_op = '0;
               end else begin
                  col_op = CW'(1);
                  we     = 1'b1;
                  waddr  = {last_row, ACW'(0)};
                  wdata  = char_ff;
               end
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase

      push_data.cur_row     = 6'(row_op);
      push_data.cur_col     = 8'(col_op);
      push_data.cell_data   = cell_byte;
      push_data.escape_busy = esc_active_in;
      push_data.did_scroll  = scrolled;
   end

   // a register write clamps the cursor into the new screen size
   always_comb begin
      row_in = row_op;
      col_in = col_op;
      if (csr_we) begin
         row_in = (RUW'(row_ff) >= rows_used_new) ? RW'(rows_used_new - RUW'(1)) : row_ff;
         col_in = (col_ff >= cols_used_new) ? CW'(cols_used_new - CUW'(1)) : col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff   <= ROWS_RESET;
         cols_cfg_ff   <= COLS_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         esc_active_ff <= 1'b0;
         esc_len_ff    <= '0;
         init_cnt_ff   <= '0;
         pend_ff       <= 1'b0;
         clear_mode_ff <= 1'b0;
      end else begin
         rows_cfg_ff   <= rows_cfg_in;
         cols_cfg_ff   <= cols_cfg_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         esc_active_ff <= esc_active_in;
         esc_len_ff    <= esc_len_in;
         init_cnt_ff   <= init_cnt_in;
         pend_ff       <= pend_in;
         clear_mode_ff <= clear_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      nl_ff        <= nl_in;
      oob_ff       <= oob_in;
      sw_row_ff    <= sw_row_in;
      sw_col_ff    <= sw_col_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   // two-deep result queue: head drives the port, tail catches the next beat
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) head_ff <= push_data;
            else tail_ff <= push_data;
         end
         2'b01: begin
            head_ff <= tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_ff <= push_data;
            end else begin
               head_ff <= tail_ff;
               tail_ff <= push_data;
            end
         end
         default: begin
            head_ff <= head_ff;
         end
      endcase
   end

endmodule

@@ sv/text_terminal_screen_writer.sv @@
// Top level of the text terminal screen writer: sequencer plus datapath.
//
// Character-cell screen with a cursor, one operation per request beat and one
// response beat per request. A byte write, cursor move or escape-swallowed
// byte is handled as it is accepted; a cell read goes through the registered
// read of the single cell memory. Clear and scroll sweep one cell per cycle
// through the memory's one write port; a scroll on a one-row screen skips the
// copy and only blanks the row. After reset a clearing pass blanks the whole
// store, all 2**(clog2(MAX_ROWS) + clog2(MAX_COLS)) cells (8192 at the default
// sizes); requests are held off meanwhile, register writes are taken.
// Up to two finished responses queue while the next request is accepted.
module text_terminal_screen_writer #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 128,
   parameter int ESC_MAX_LEN = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // char_byte[7:0], target_row[13:8], target_col[20:14], zero [23:21]
   input  logic [ttsw_pkg::REQ_DATA_W-1:0]       req_tdata,
   // opcode[1:0]
   input  logic [ttsw_pkg::OP_W-1:0]             req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // cur_row[5:0], cur_col[13:6], cell_data[21:14], escape_busy[22], did_scroll[23]
   output logic [ttsw_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                 csr_we,
   input  logic [ttsw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ttsw_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ttsw_pkg::*;

   ttsw_cmd_type    cmd;
   ttsw_status_type status;

   ttsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ttsw_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .ESC_MAX_LEN (ESC_MAX_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ tb/sv/text_terminal_screen_writer_test.sv @@
// Self-checking testbench for the text terminal screen writer: random streams against a cursor model.
`timescale 1ns / 100ps

module text_terminal_screen_writer_test;
   import ttsw_pkg::*;

   localparam int CYCLE_LIMIT = 50_000_000;
   localparam int OPS_TARGET  = 1200;

   typedef struct {
      logic [OP_W-1:0] op;
      logic [7:0]      ch;
      logic [5:0]      trow;
      logic [6:0]      tcol;
   } term_op_type;

   // Screen contents, cursor and escape state; predicts one status beat per operation.
   class screen_model;
      localparam int ROWS_MAX  = 64;
      localparam int COLS_MAX  = 128;
      localparam int ESC_LIMIT = 30;

      logic [7:0]   cells [ROWS_MAX*COLS_MAX];
      int unsigned  row_at;
      int unsigned  col_at;
      bit           esc_on;
      int unsigned  esc_count;
      logic [6:0]   rows_reg;
      logic [7:0]   cols_reg;
      ttsw_rsp_type status_q [$];
      int unsigned  fail_count;
      int unsigned  beats_checked;

      function new();
         foreach (cells[i]) cells[i] = CH_BLANK;
         row_at        = 0;
         col_at        = 0;
         esc_on        = 1'b0;
         esc_count     = 0;
         rows_reg      = ROWS_RESET;
         cols_reg      = COLS_RESET;
         fail_count    = 0;
         beats_checked = 0;
      endfunction

      function int unsigned rows_used();
         if (rows_reg == 0) return 1;
         if (rows_reg > ROWS_MAX) return ROWS_MAX;
         return 32'(rows_reg);
      endfunction

      function int unsigned cols_used();
         if (cols_reg == 0) return 1;
         if (cols_reg > COLS_MAX) return COLS_MAX;
         return 32'(cols_reg);
      endfunction

      function bit is_letter(logic [7:0] b);
         return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
      endfunction

      // a resize pulls the cursor back inside the screen
      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         if (idx == REG_SCREEN_ROWS) rows_reg = val[6:0];
         else cols_reg = val;
         if (row_at >= rows_used()) row_at = rows_used() - 1;
         if (col_at >= cols_used()) col_at = cols_used() - 1;
      endfunction

      function void scroll_up();
         int unsigned nr;
         int unsigned nc;
         int unsigned r;
         int unsigned c;
         nr = rows_used();
         nc = cols_used();
         for (r = 0; r + 1 < nr; r++)
            for (c = 0; c < nc; c++)
               cells[r*COLS_MAX + c] = cells[(r+1)*COLS_MAX + c];
         for (c = 0; c < nc; c++) cells[(nr-1)*COLS_MAX + c] = CH_BLANK;
      endfunction

      function bit put_byte(logic [7:0] ch);
         int unsigned nr;
         int unsigned nc;
         bit rolled;
         nr     = rows_used();
         nc     = cols_used();
         rolled = 1'b0;
         if (esc_on) begin
            if (ch == CH_NUL) begin
               esc_on    = 1'b0;
               esc_count = 0;
            end else begin
               esc_count++;
               if (is_letter(ch) || esc_count >= ESC_LIMIT) begin
                  esc_on    = 1'b0;
                  esc_count = 0;
               end
            end
            return 1'b0;
         end
         case (ch)
            CH_NUL: ;
            CH_ESC: begin
               esc_on    = 1'b1;
               esc_count = 0;
            end
            CH_LF: begin
               row_at++;
               col_at = 0;
               if (row_at >= nr) begin
                  scroll_up();
                  rolled = 1'b1;
                  row_at = nr - 1;
               end
            end
            CH_CR: col_at = 0;
            CH_BS, CH_DEL: begin
               if (col_at > 0) begin
                  col_at--;
                  cells[row_at*COLS_MAX + col_at] = CH_BLANK;
               end
            end
            default: begin
               // wrap a pending column first, then scroll if that ran off the bottom
               if (col_at >= nc) begin
                  row_at++;
                  col_at = 0;
               end
               if (row_at >= nr) begin
                  scroll_up();
                  rolled = 1'b1;
                  row_at = nr - 1;
               end
               cells[row_at*COLS_MAX + col_at] = ch;
               col_at++;
            end
         endcase
         return rolled;
      endfunction

      function void note_op(term_op_type t);
         ttsw_rsp_type s;
         int unsigned  r;
         int unsigned  c;
         s = '0;
         case (t.op)
            OP_WRITE: s.did_scroll = put_byte(t.ch);
            OP_MOVE: begin
               if (t.trow < rows_used()) row_at = 32'(t.trow);
               if (t.tcol < cols_used()) col_at = 32'(t.tcol);
            end
            OP_CLEAR: begin
               for (r = 0; r < rows_used(); r++)
                  for (c = 0; c < cols_used(); c++) cells[r*COLS_MAX + c] = CH_BLANK;
               row_at = 0;
               col_at = 0;
            end
            OP_READ: s.cell_data = cells[t.trow*COLS_MAX + t.tcol];
            default: ;
         endcase
         s.cur_row     = row_at[5:0];
         s.cur_col     = col_at[7:0];
         s.escape_busy = esc_on;
         status_q.push_back(s);
      endfunction

      function void check_status(ttsw_rsp_type got);
         ttsw_rsp_type want;
         beats_checked++;
         if (status_q.size() == 0) begin
            if (fail_count < 10)
               $display("ERROR: beat %0d arrived with nothing expected: %h", beats_checked, got);
            fail_count++;
            return;
         end
         want = status_q.pop_front();
         if (got.cur_row !== want.cur_row || got.cur_col !== want.cur_col ||
             got.cell_data !== want.cell_data || got.escape_busy !== want.escape_busy ||
             got.did_scroll !== want.did_scroll) begin
            if (fail_count < 10)
               $display("ERROR: beat %0d expected row %0d col %0d cell %h esc %b scroll %b, %s",
                        beats_checked, want.cur_row, want.cur_col, want.cell_data,
                        want.escape_busy, want.did_scroll,
                        $sformatf("got row %0d col %0d cell %h esc %b scroll %b",
                                  got.cur_row, got.cur_col, got.cell_data,
                                  got.escape_busy, got.did_scroll));
            fail_count++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   screen_model screen;
   term_op_type op_plan [$];
   bit          steady      = 1'b0;   // no idling on either side while set
   int unsigned rsp_hold    = 0;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   text_terminal_screen_writer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: check each beat, then stall for a drawn number of cycles
   always @(posedge clock) begin
      int unsigned hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         screen.check_status(rsp_tdata);
         hold = steady ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= hold;
         end
      end else if (!rsp_tready) begin
         if (rsp_hold <= 1) rsp_tready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   task automatic send_op(term_op_type t);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= t.op;
      req_tdata  <= {3'b000, t.tcol, t.trow, t.ch};
      do @(posedge clock); while (req_tready !== 1'b1);
      screen.note_op(t);
   endtask

   // hold off until every status beat is back, then let the block settle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (screen.status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_screen(logic [7:0] rows_val, logic [7:0] cols_val);
      bit rows_first;
      rows_first = 1'($urandom_range(0, 1));
      csr_we    <= 1'b1;
      csr_index <= rows_first ? REG_SCREEN_ROWS : REG_SCREEN_COLS;
      csr_wdata <= rows_first ? rows_val : cols_val;
      @(posedge clock);
      screen.set_reg(rows_first ? REG_SCREEN_ROWS : REG_SCREEN_COLS,
                     rows_first ? rows_val : cols_val);
      csr_index <= rows_first ? REG_SCREEN_COLS : REG_SCREEN_ROWS;
      csr_wdata <= rows_first ? cols_val : rows_val;
      @(posedge clock);
      screen.set_reg(rows_first ? REG_SCREEN_COLS : REG_SCREEN_ROWS,
                     rows_first ? cols_val : rows_val);
      csr_we <= 1'b0;
   endtask

   function automatic void add_op(logic [OP_W-1:0] op, logic [7:0] ch, logic [5:0] r,
                                  logic [6:0] c);
      term_op_type t;
      t.op   = op;
      t.ch   = ch;
      t.trow = r;
      t.tcol = c;
      op_plan.push_back(t);
   endfunction

   // target fields mean nothing on a write, so fill them with noise
   function automatic void add_byte(logic [7:0] ch);
      add_op(OP_WRITE, ch, 6'($urandom), 7'($urandom));
   endfunction

   function automatic logic [7:0] any_letter();
      return 8'($urandom_range(0, 1) ? $urandom_range(CH_UPPER_A, CH_UPPER_Z)
                                     : $urandom_range(CH_LOWER_A, CH_LOWER_Z));
   endfunction

   // queue one short, mostly well-formed stretch of terminal traffic
   function automatic void plan_burst(bit big);
      int unsigned      pick;
      int unsigned      n;
      int unsigned      nr;
      int unsigned      nc;
      logic [7:0]       b;
      logic [5:0]       r;
      logic [6:0]       c;
      logic [OP_W-1:0]  op;
      nr   = screen.rows_used();
      nc   = screen.cols_used();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         n = $urandom_range(1, 24);
         repeat (n)
            add_byte(8'(($urandom_range(0, 9) == 0) ? $urandom_range(128, 255)
                                                    : $urandom_range(32, 126)));
         case ($urandom_range(0, 3))
            0: add_byte(CH_LF);
            1: begin
               add_byte(CH_CR);
               add_byte(CH_LF);
            end
            default: ;
         endcase
      end else if (pick < 55) begin
         add_byte(CH_ESC);
         n = $urandom_range(0, 34);
         repeat (n) begin
            case ($urandom_range(0, 7))
               0: add_byte(CH_ESC);
               1: add_op(OP_READ, 8'($urandom), 6'($urandom), 7'($urandom));
               2: add_op(OP_MOVE, 8'($urandom), 6'($urandom_range(0, nr - 1)),
                         7'($urandom));
               3, 4: add_byte(8'($urandom_range(8'h30, 8'h3F)));
               default: begin
                  b = 8'($urandom);
                  if (screen.is_letter(b)) b[6] = 1'b0;
                  add_byte(b);
               end
            endcase
         end
         case ($urandom_range(0, 3))
            0, 1: add_byte(any_letter());
            2: add_byte(CH_NUL);
            default: ;
         endcase
      end else if (pick < 65) begin
         n = $urandom_range(1, 4);
         case ($urandom_range(0, 3))
            0: repeat (n) add_byte(CH_BS);
            1: repeat (n) add_byte(CH_DEL);
            2: add_byte(CH_CR);
            default: repeat (n) add_byte(CH_LF);
         endcase
      end else if (pick < 77) begin
         // small screens lean on the last row, every screen on the last column, to force scrolls and wraps
         if ($urandom_range(0, 3) == 0) r = 6'($urandom);
         else if (!big && $urandom_range(0, 2) == 0) r = 6'(nr - 1);
         else r = 6'($urandom_range(0, nr - 1));
         if ($urandom_range(0, 3) == 0) c = 7'($urandom);
         else if ($urandom_range(0, 2) == 0) c = 7'(nc - 1);
         else c = 7'($urandom_range(0, nc - 1));
         add_op(OP_MOVE, 8'($urandom), r, c);
      end else if (pick < 89) begin
         if ($urandom_range(0, 1))
            add_op(OP_READ, 8'($urandom), 6'($urandom), 7'($urandom));
         else
            add_op(OP_READ, 8'($urandom), 6'($urandom_range(0, nr - 1)),
                   7'($urandom_range(0, nc - 1)));
      end else if (pick < 92) begin
         if (!big || $urandom_range(0, 7) == 0)
            add_op(OP_CLEAR, 8'($urandom), 6'($urandom), 7'($urandom));
      end else begin
         op = OP_W'($urandom);
         if (big && op == OP_CLEAR) op = OP_READ;
         add_op(op, 8'($urandom), 6'($urandom), 7'($urandom));
      end
   endfunction

   initial begin
      int unsigned phase;
      int unsigned quota;
      int unsigned done;
      int unsigned ops_sent;
      bit          big;
      logic [7:0]  rows_val;
      logic [7:0]  cols_val;
      term_op_type t;

      screen = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening on the reset-size screen
      add_op(OP_READ, 8'h00, 6'd0, 7'd0);
      add_op(OP_READ, 8'hFF, 6'd63, 7'd127);
      add_byte(CH_UPPER_A);
      add_byte(8'hFF);
      add_byte(8'h01);
      add_byte(CH_BS);
      add_byte(CH_DEL);
      add_byte(CH_CR);
      add_byte(CH_BS);
      add_byte(CH_LF);
      add_op(OP_MOVE, 8'h00, 6'd63, 7'd127);
      add_op(OP_MOVE, 8'h00, 6'd23, 7'd79);
      add_byte(CH_LOWER_Z);
      add_byte(CH_UPPER_Z);
      add_byte(CH_LF);
      add_byte(CH_ESC);
      add_op(OP_MOVE, 8'h00, 6'd2, 7'd5);
      add_byte(CH_ESC);
      add_byte(8'h5B);
      add_byte(CH_LOWER_A);
      add_byte(CH_ESC);
      add_byte(CH_NUL);
      add_byte(CH_NUL);
      add_op(OP_READ, 8'h00, 6'd22, 7'd0);
      add_op(OP_CLEAR, 8'h00, 6'd0, 7'd0);
      add_op(OP_READ, 8'h00, 6'd22, 7'd0);
      while (op_plan.size() != 0) send_op(op_plan.pop_front());
      drain_and_settle();

      ops_sent = 0;
      phase    = 0;
      while (ops_sent < OPS_TARGET) begin
         case (phase)
            0: begin
               rows_val = 8'd1;
               cols_val = 8'd1;
            end
            1: begin
               rows_val = 8'd0;
               cols_val = 8'd0;
            end
            2: begin
               rows_val = 8'd64;
               cols_val = 8'd128;
            end
            3: begin
               rows_val = 8'hFF;
               cols_val = 8'hFF;
            end
            4: begin
               rows_val = 8'h98;
               cols_val = 8'd80;
            end
            default: begin
               rows_val = 8'($urandom_range(1, 16) | ($urandom_range(0, 1) << 7));
               cols_val = 8'($urandom_range(1, 40));
            end
         endcase
         set_screen(rows_val, cols_val);
         big    = screen.rows_used() * screen.cols_used() > 1000;
         steady = ($urandom_range(0, 3) == 0);
         quota  = big ? 40 : 60;
         op_plan.delete();
         done = 0;
         while (done < quota) begin
            if (op_plan.size() == 0) plan_burst(big);
            t = op_plan.pop_front();
            send_op(t);
            // a stray NUL does nothing, so leave it out of the count
            if (!(t.op == OP_WRITE && t.ch == CH_NUL)) done++;
         end
         ops_sent += done;
         drain_and_settle();
         phase++;
      end

      repeat (20) @(posedge clock);
      if (screen.fail_count == 0 && screen.status_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
